/* design/triangle_tangent_generator_assert.svh */
// Assertion macros for the triangle tangent generator checker.
// No dependencies; included by the checker file only.
`ifndef TRIANGLE_TANGENT_GENERATOR_ASSERT_SVH
`define TRIANGLE_TANGENT_GENERATOR_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define TTG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also applies during reset.
`define TTG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* design/ttg_pkg.sv */
// Shared types, widths and codes for the triangle tangent generator.
// No dependencies.
package ttg_pkg;

    localparam int DP_W   = 33;  // position edge delta
    localparam int UV_W   = 17;  // texture edge delta
    localparam int MA_W   = 35;  // multiplier operand a
    localparam int MB_W   = 18;  // multiplier operand b
    localparam int PR_W   = MA_W + MB_W;
    localparam int ACC_W  = 52;  // tangent direction / determinant
    localparam int MAG_W  = ACC_W - 1;
    localparam int M16_W  = 16;  // normalised magnitude
    localparam int SQ_W   = 32;
    localparam int SUM_W  = 34;
    localparam int HALF_W = 17;  // half of the sum of squares
    localparam int K_W    = 16;
    localparam int K2_W   = 30;
    localparam int PLO_W  = K2_W + HALF_W;
    localparam int CMP_W  = 64;
    localparam int Q_W    = 15;
    localparam int BIT_W  = 4;

    localparam logic [Q_W-1:0]   ONE_Q14  = 15'd16384;
    localparam logic [BIT_W-1:0] TOP_BIT  = 4'd14;
    localparam logic [1:0]       LAST_IDX = 2'd2;

    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
    } ttg_in_t;

    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic               degenerate;
    } ttg_out_t;

    typedef struct packed {
        logic                  zero_out;
        logic [2:0][DP_W-1:0]  dp1;
        logic [2:0][DP_W-1:0]  dp2;
        logic [UV_W-1:0]       du1;
        logic [UV_W-1:0]       dv1;
        logic [UV_W-1:0]       du2;
        logic [UV_W-1:0]       dv2;
    } ttg_job_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DET_A, ST_DET_B, ST_DET_C,
        ST_T_A, ST_T_B, ST_T_C, ST_CHECK,
        ST_SHIFT, ST_SQ_A, ST_SQ_B, ST_Q_K,
        ST_Q_L, ST_Q_H, ST_Q_D, ST_DONE
    } ttg_state_t;

endpackage

/* design/ttg_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on ttg_pkg.
module ttg_mul import ttg_pkg::*; (
    input  logic                    aclk,
    input  logic signed [MA_W-1:0]  op_a,
    input  logic signed [MB_W-1:0]  op_b,
    output logic signed [PR_W-1:0]  prod
);

    logic signed [PR_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PR_W'(op_a * op_b);
    end

    assign prod = prod_reg;

endmodule

/* design/ttg_seq.sv */
// Sequencer and datapath: determinant, tangent, scaling and per-component root search.
// Depends on ttg_pkg and ttg_mul.
module ttg_seq import ttg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    input  ttg_job_t job,
    input  logic     out_free,
    output logic     idle,
    output logic     done,
    output ttg_out_t result
);

    ttg_state_t state_reg, state_next;

    ttg_job_t               job_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                   det_neg_reg, det_zero_reg;
    logic [MAG_W-1:0]       mag_reg [3];
    logic                   neg_reg [3];
    logic [SQ_W-1:0]        csq_reg [3];
    logic [Q_W-1:0]         qres_reg [3];
    logic [SUM_W-1:0]       sum_reg;
    logic [1:0]             idx_reg;
    logic [BIT_W-1:0]       bit_reg;
    logic [Q_W-1:0]         q_reg;
    logic [K2_W-1:0]        k2_reg;
    logic [PLO_W-1:0]       plo_reg;
    logic                   degen_reg, zero_reg;

    logic signed [MA_W-1:0] op_a;
    logic signed [MB_W-1:0] op_b;
    logic signed [PR_W-1:0] prod;

    logic signed [ACC_W-1:0] diff;
    logic [Q_W-1:0]          cand;
    logic [K_W-1:0]          k_val;
    logic [CMP_W-1:0]        lhs, rhs;
    logic                    cand_ok;
    logic                    big;
    logic                    all_zero;

    ttg_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign diff     = acc_reg - prod[ACC_W-1:0];
    assign cand     = q_reg | (Q_W'(1) << bit_reg);
    assign k_val    = {cand, 1'b0} - K_W'(1);
    assign lhs      = {prod[PLO_W-1:0], {HALF_W{1'b0}}} + CMP_W'(plo_reg);
    assign rhs      = CMP_W'({csq_reg[idx_reg], 30'b0});
    assign cand_ok  = (cand <= ONE_Q14) && (lhs <= rhs);
    assign big      = (|mag_reg[0][MAG_W-1:M16_W]) | (|mag_reg[1][MAG_W-1:M16_W])
                    | (|mag_reg[2][MAG_W-1:M16_W]);
    assign all_zero = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);

    // operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_DET_A: begin
                op_a = MA_W'($signed(job_reg.du1));
                op_b = MB_W'($signed(job_reg.dv2));
            end
            ST_DET_B: begin
                op_a = MA_W'($signed(job_reg.dv1));
                op_b = MB_W'($signed(job_reg.du2));
            end
            ST_T_A: begin
                op_a = MA_W'($signed(job_reg.dp1[idx_reg]));
                op_b = MB_W'($signed(job_reg.dv2));
            end
            ST_T_B: begin
                op_a = MA_W'($signed(job_reg.dp2[idx_reg]));
                op_b = MB_W'($signed(job_reg.dv1));
            end
            ST_SQ_A: begin
                op_a = $signed(MA_W'(mag_reg[idx_reg][M16_W-1:0]));
                op_b = $signed(MB_W'(mag_reg[idx_reg][M16_W-1:0]));
            end
            ST_Q_K: begin
                op_a = $signed(MA_W'(k_val));
                op_b = $signed(MB_W'(k_val));
            end
            ST_Q_L: begin
                op_a = $signed(MA_W'(prod[K2_W-1:0]));
                op_b = $signed(MB_W'(sum_reg[HALF_W-1:0]));
            end
            ST_Q_H: begin
                op_a = $signed(MA_W'(k2_reg));
                op_b = $signed(MB_W'(sum_reg[SUM_W-1:HALF_W]));
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = job.zero_out ? ST_DONE : ST_DET_A;
            ST_DET_A: state_next = ST_DET_B;
            ST_DET_B: state_next = ST_DET_C;
            ST_DET_C: state_next = ST_T_A;
            ST_T_A:   state_next = ST_T_B;
            ST_T_B:   state_next = ST_T_C;
            ST_T_C:   state_next = (idx_reg == LAST_IDX) ? ST_CHECK : ST_T_A;
            ST_CHECK: state_next = (det_zero_reg || all_zero) ? ST_DONE : ST_SHIFT;
            ST_SHIFT: state_next = big ? ST_SHIFT : ST_SQ_A;
            ST_SQ_A:  state_next = ST_SQ_B;
            ST_SQ_B:  state_next = (idx_reg == LAST_IDX) ? ST_Q_K : ST_SQ_A;
            ST_Q_K:   state_next = ST_Q_L;
            ST_Q_L:   state_next = ST_Q_H;
            ST_Q_H:   state_next = ST_Q_D;
            ST_Q_D: begin
                if (bit_reg == '0 && idx_reg == LAST_IDX) state_next = ST_DONE;
                else                                       state_next = ST_Q_K;
            end
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    job_reg   <= job;
                    idx_reg   <= '0;
                    degen_reg <= 1'b0;
                    zero_reg  <= job.zero_out;
                end
            end
            ST_DET_B: acc_reg <= prod[ACC_W-1:0];
            ST_DET_C: begin
                det_neg_reg  <= diff[ACC_W-1];
                det_zero_reg <= (diff == '0);
                idx_reg      <= '0;
            end
            ST_T_B: acc_reg <= prod[ACC_W-1:0];
            ST_T_C: begin
                neg_reg[idx_reg] <= diff[ACC_W-1] ^ det_neg_reg;
                mag_reg[idx_reg] <= diff[ACC_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
                idx_reg          <= (idx_reg == LAST_IDX) ? 2'd0 : idx_reg + 2'd1;
            end
            ST_CHECK: begin
                sum_reg <= '0;
                idx_reg <= '0;
                if (det_zero_reg || all_zero) begin
                    degen_reg <= 1'b1;
                    zero_reg  <= 1'b1;
                end
            end
            ST_SHIFT: begin
                if (big) begin
                    mag_reg[0] <= mag_reg[0] >> 1;
                    mag_reg[1] <= mag_reg[1] >> 1;
                    mag_reg[2] <= mag_reg[2] >> 1;
                end
            end
            ST_SQ_B: begin
                csq_reg[idx_reg] <= prod[SQ_W-1:0];
                sum_reg          <= sum_reg + SUM_W'(prod[SQ_W-1:0]);
                idx_reg          <= (idx_reg == LAST_IDX) ? 2'd0 : idx_reg + 2'd1;
                bit_reg          <= TOP_BIT;
                q_reg            <= '0;
            end
            ST_Q_L: k2_reg  <= prod[K2_W-1:0];
            ST_Q_H: plo_reg <= prod[PLO_W-1:0];
            ST_Q_D: begin
                if (bit_reg == '0) begin
                    qres_reg[idx_reg] <= cand_ok ? cand : q_reg;
                    q_reg             <= '0;
                    bit_reg           <= TOP_BIT;
                    idx_reg           <= (idx_reg == LAST_IDX) ? 2'd0 : idx_reg + 2'd1;
                end else begin
                    if (cand_ok) q_reg <= cand;
                    bit_reg <= bit_reg - BIT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        idle   = (state_reg == ST_IDLE);
        done   = (state_reg == ST_DONE);
        result = '0;
        result.degenerate = degen_reg;
        if (!zero_reg) begin
            result.tangent_x = neg_reg[0] ? -{1'b0, qres_reg[0]} : {1'b0, qres_reg[0]};
            result.tangent_y = neg_reg[1] ? -{1'b0, qres_reg[1]} : {1'b0, qres_reg[1]};
            result.tangent_z = neg_reg[2] ? -{1'b0, qres_reg[2]} : {1'b0, qres_reg[2]};
        end
    end

endmodule

/* design/triangle_tangent_generator.sv */
// Triangle tangent generator: a triangle arrives as three vertex transfers
// (corner 0, 1, 2). Corners 0 and 1 are held; corner 2 starts the tangent
// calculation and yields one result transfer. Corner codes of 3 are dropped.
// A corner 2 transfer occupies the block: all products share one 35x18
// multiplier under the sequencer (determinant and direction, the degeneracy
// check, the one-bit-per-cycle scaling shift, the squares, then 15 root-search
// steps per component, then handing the result over). s_ready is low for that
// whole time, and stays low while a finished result waits for the output
// register to free.
// With uv_present low, corner 2 gives the zero vector with degenerate clear.
// Degenerate triangles give zero with the flag set.
// Depends on ttg_pkg, ttg_mul, ttg_seq.
module triangle_tangent_generator import ttg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    // vertex input
    input  logic     s_valid,
    output logic     s_ready,
    input  ttg_in_t  s_data,
    // tangent output
    output logic     m_valid,
    input  logic     m_ready,
    output ttg_out_t m_data,
    // configuration: uv_present
    input  logic     cfg_wr_en,
    input  logic     cfg_wr_data
);

    logic uv_present_reg;

    // corners 0 and 1, no reset: never read before written in valid use
    logic [31:0] pos0_reg [3];
    logic [31:0] pos1_reg [3];
    logic [15:0] tex0_reg [2];
    logic [15:0] tex1_reg [2];

    logic     m_valid_reg;
    ttg_out_t m_data_reg;

    logic     in_xfer, start, out_free, core_idle, core_done;
    ttg_job_t job;
    ttg_out_t core_res;
    logic [31:0] pos_in [3];

    assign pos_in[0] = s_data.pos_x;
    assign pos_in[1] = s_data.pos_y;
    assign pos_in[2] = s_data.pos_z;

    assign s_ready  = core_idle;
    assign in_xfer  = s_valid && s_ready;
    assign start    = in_xfer && (s_data.corner == CORNER_2);
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn)       uv_present_reg <= 1'b1;
        else if (cfg_wr_en) uv_present_reg <= cfg_wr_data;
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && s_data.corner == CORNER_0) begin
            pos0_reg    <= pos_in;
            tex0_reg[0] <= s_data.tex_u;
            tex0_reg[1] <= s_data.tex_v;
        end
        if (in_xfer && s_data.corner == CORNER_1) begin
            pos1_reg    <= pos_in;
            tex1_reg[0] <= s_data.tex_u;
            tex1_reg[1] <= s_data.tex_v;
        end
    end

    // edge deltas, sign-extended one bit so they never wrap
    always_comb begin
        job.zero_out = !uv_present_reg;
        for (int i = 0; i < 3; i++) begin
            job.dp1[i] = DP_W'($signed(pos1_reg[i])) - DP_W'($signed(pos0_reg[i]));
            job.dp2[i] = DP_W'($signed(pos_in[i]))   - DP_W'($signed(pos0_reg[i]));
        end
        job.du1 = UV_W'($signed(tex1_reg[0]))   - UV_W'($signed(tex0_reg[0]));
        job.dv1 = UV_W'($signed(tex1_reg[1]))   - UV_W'($signed(tex0_reg[1]));
        job.du2 = UV_W'($signed(s_data.tex_u))  - UV_W'($signed(tex0_reg[0]));
        job.dv2 = UV_W'($signed(s_data.tex_v))  - UV_W'($signed(tex0_reg[1]));
    end

    ttg_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .job      (job),
        .out_free (out_free),
        .idle     (core_idle),
        .done     (core_done),
        .result   (core_res)
    );

    // output register: result waits here until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_done && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_done && out_free) m_data_reg <= core_res;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/ttg_checker.sv */
// Port-level checks on the triangle tangent generator, bound to the top level.
// Depends on ttg_pkg and triangle_tangent_generator_assert.svh.
`include "triangle_tangent_generator_assert.svh"

module ttg_port_checks import ttg_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input ttg_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input ttg_out_t m_data
);

    logic tri_xfer, tan_zero, tan_in_range;

    assign tri_xfer = s_valid && s_ready && (s_data.corner == CORNER_2);
    assign tan_zero = (m_data.tangent_x == 16'sd0) && (m_data.tangent_y == 16'sd0)
                    && (m_data.tangent_z == 16'sd0);
    assign tan_in_range = (m_data.tangent_x <= 16'sd16384) && (m_data.tangent_x >= -16'sd16384)
                        && (m_data.tangent_y <= 16'sd16384) && (m_data.tangent_y >= -16'sd16384)
                        && (m_data.tangent_z <= 16'sd16384) && (m_data.tangent_z >= -16'sd16384);

    `TTG_ASSERT_RST(a_no_result_after_reset, !aresetn |=> !m_valid, "result valid after reset")
    `TTG_ASSERT(a_result_holds, m_valid && !m_ready |=> m_valid && $stable(m_data), "result moved")
    `TTG_ASSERT(a_degenerate_zero, m_valid && m_data.degenerate |-> tan_zero, "degenerate not zero")
    `TTG_ASSERT(a_unit_range, m_valid |-> tan_in_range, "tangent component beyond one")
    `TTG_ASSERT(a_busy_after_triangle, tri_xfer |=> !s_ready, "input ready while busy")

endmodule

bind triangle_tangent_generator ttg_port_checks u_ttg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
